// ===== rtl/core/i2cme_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cme_pkg
// Shared types and constants of the I2C master byte engine: the input and
// result words, the decoded operation word and the command and register codes.
// ----------------------------------------------------------------------------
package i2cme_pkg;

  localparam int unsigned CMD_W      = 3;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned BIT_IDX_W  = 4;

  localparam logic [CMD_W-1:0] CMD_TICK     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_START    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_STOP     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_WRITE    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ     = 3'd4;
  localparam logic [CMD_W-1:0] CMD_SEND_ACK = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RETRIES = 2'd1;

  localparam logic [BYTE_W-1:0]   RETRY_SAT    = 8'hFF;
  localparam logic [BIT_IDX_W-1:0] BITS_PER_BYTE = 4'd8;

  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_WRITE = 3'd3,
    OP_READ  = 3'd4,
    OP_ACK   = 3'd5
  } op_e;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [BYTE_W-1:0] data_byte;
    logic              ack_bit;
    logic              sda_in;
  } in_word_t;

  typedef struct packed {
    logic              scl_level;
    logic              sda_level;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] read_data;
    logic              gave_up;
    logic [BYTE_W-1:0] retry_count;
  } out_word_t;

  typedef struct packed {
    op_e               op;
    logic [BYTE_W-1:0] data_byte;
    logic              ack_bit;
    logic              sda_in;
  } op_word_t;

  typedef struct packed {
    logic push;
    logic full;
  } q_ctrl_t;

endpackage

// ===== rtl/core/i2cme_front.sv =====
// ----------------------------------------------------------------------------
// i2cme_front
// Input side: takes command words, decodes the command code into an
// operation and pushes the decoded word into the operation queue.
// ----------------------------------------------------------------------------
module i2cme_front (
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  i2cme_pkg::in_word_t in_word_i,
  input  logic                q_full_i,
  output i2cme_pkg::q_ctrl_t  q_ctrl_o,
  output i2cme_pkg::op_word_t q_word_o
);
  import i2cme_pkg::*;

  op_e op;

  always_comb begin
    case (in_word_i.command)
      CMD_START:    op = OP_START;
      CMD_STOP:     op = OP_STOP;
      CMD_WRITE:    op = OP_WRITE;
      CMD_READ:     op = OP_READ;
      CMD_SEND_ACK: op = OP_ACK;
      default:      op = OP_NONE;
    endcase
  end

  assign in_stall_o         = q_full_i;
  assign q_ctrl_o.full      = q_full_i;
  assign q_ctrl_o.push      = in_valid_i && !q_full_i;
  assign q_word_o.op        = op;
  assign q_word_o.data_byte = in_word_i.data_byte;
  assign q_word_o.ack_bit   = in_word_i.ack_bit;
  assign q_word_o.sda_in    = in_word_i.sda_in;

endmodule

// ===== rtl/core/i2cme_queue.sv =====
// ----------------------------------------------------------------------------
// i2cme_queue
// Two-entry queue of decoded operation words between front and back.
// ----------------------------------------------------------------------------
module i2cme_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  i2cme_pkg::q_ctrl_t  ctrl_i,
  input  i2cme_pkg::op_word_t wr_word_i,
  input  logic                pop_i,
  output logic                full_o,
  output logic                valid_o,
  output i2cme_pkg::op_word_t rd_word_o
);
  import i2cme_pkg::*;

  op_word_t   entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = ctrl_i.push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(ctrl_i.push) - 2'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      entry_q[wr_ptr_q] <= wr_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  assign full_o    = count_q == 2'd2;
  assign valid_o   = count_q != 2'd0;
  assign rd_word_o = entry_q[rd_ptr_q];

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != 2'd0)
    else $error("pop from empty queue");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.push |-> !ctrl_i.full)
    else $error("push into full queue");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("queue count out of range");

endmodule

// ===== rtl/core/i2cme_back.sv =====
// ----------------------------------------------------------------------------
// i2cme_back
// Bus timing engine: steps the SCL/SDA state machine once per operation word
// and registers the result word toward the output channel.
// ----------------------------------------------------------------------------
module i2cme_back #(
  parameter int unsigned DIV_WIDTH = 10
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [i2cme_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [i2cme_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                                 q_valid_i,
  input  i2cme_pkg::op_word_t                  q_word_i,
  output logic                                 q_pop_o,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output i2cme_pkg::out_word_t                 out_word_o
);
  import i2cme_pkg::*;

  typedef enum logic [15:0] {
    PH_IDLE       = 16'h0001,
    PH_ST_HI      = 16'h0002,
    PH_ST_FALL    = 16'h0004,
    PH_SP_LO      = 16'h0008,
    PH_SP_RISE    = 16'h0010,
    PH_AK_HI      = 16'h0020,
    PH_AK_LO      = 16'h0040,
    PH_WR_SET     = 16'h0080,
    PH_WR_HIGH    = 16'h0100,
    PH_NK_LO      = 16'h0200,
    PH_RS_SP_LO   = 16'h0400,
    PH_RS_SP_RISE = 16'h0800,
    PH_RS_ST_HI   = 16'h1000,
    PH_RS_ST_FALL = 16'h2000,
    PH_RD_HIGH    = 16'h4000,
    PH_RD_LOW     = 16'h8000
  } phase_e;

  logic [DIV_WIDTH-1:0] half_q;
  logic [BYTE_W-1:0]    max_retry_q;

  phase_e               phase_q, phase_d;
  logic [BIT_IDX_W-1:0] bit_q, bit_d;
  logic [BYTE_W-1:0]    shift_q, shift_d;
  logic [BYTE_W-1:0]    held_q, held_d;
  logic [DIV_WIDTH-1:0] tick_q, tick_d;
  logic [BYTE_W-1:0]    retries_q, retries_d;
  logic                 scl_q, scl_d;
  logic                 sda_q, sda_d;
  logic                 gave_q, gave_d;
  logic                 done;

  logic                 out_valid_q;
  out_word_t            out_word_q, out_word_d;

  logic [DIV_WIDTH-1:0] half_eff;
  logic [DIV_WIDTH-1:0] limit;
  logic [DIV_WIDTH-1:0] tick_inc;
  logic [BIT_IDX_W-1:0] bit_inc;
  logic                 step;

  assign step     = q_valid_i && (!out_valid_q || !out_stall_i);
  assign q_pop_o  = step;
  assign half_eff = (half_q == '0) ? DIV_WIDTH'(1) : half_q;
  assign limit    = (phase_q == PH_WR_SET) ? DIV_WIDTH'(1) : half_eff;
  assign tick_inc = tick_q + DIV_WIDTH'(1);
  assign bit_inc  = bit_q + BIT_IDX_W'(1);

  always_comb begin
    phase_d   = phase_q;
    bit_d     = bit_q;
    shift_d   = shift_q;
    held_d    = held_q;
    tick_d    = tick_q;
    retries_d = retries_q;
    scl_d     = scl_q;
    sda_d     = sda_q;
    gave_d    = gave_q;
    done      = 1'b0;
    if (phase_q == PH_IDLE) begin
      case (q_word_i.op)
        OP_START: begin
          phase_d = PH_ST_HI;
          scl_d   = 1'b1;
          sda_d   = 1'b1;
          tick_d  = '0;
        end
        OP_STOP: begin
          phase_d = PH_SP_LO;
          scl_d   = 1'b1;
          sda_d   = 1'b0;
          tick_d  = '0;
        end
        OP_WRITE: begin
          held_d    = q_word_i.data_byte;
          bit_d     = '0;
          retries_d = '0;
          gave_d    = 1'b0;
          phase_d   = PH_WR_SET;
          scl_d     = 1'b0;
          sda_d     = q_word_i.data_byte[BYTE_W-1];
          tick_d    = '0;
        end
        OP_READ: begin
          shift_d = '0;
          bit_d   = '0;
          phase_d = PH_RD_HIGH;
          scl_d   = 1'b1;
          sda_d   = 1'b1;
          tick_d  = '0;
        end
        OP_ACK: begin
          phase_d = PH_AK_HI;
          scl_d   = 1'b1;
          sda_d   = q_word_i.ack_bit;
          tick_d  = '0;
        end
        default: begin
        end
      endcase
    end else begin
      tick_d = tick_inc;
      if (tick_inc >= limit) begin
        tick_d = '0;
        case (phase_q)
          PH_ST_HI: begin
            phase_d = PH_ST_FALL;
            scl_d   = 1'b1;
            sda_d   = 1'b0;
          end
          PH_ST_FALL: begin
            phase_d = PH_IDLE;
            scl_d   = 1'b0;
            sda_d   = 1'b0;
            done    = 1'b1;
          end
          PH_SP_LO: begin
            phase_d = PH_SP_RISE;
            scl_d   = 1'b1;
            sda_d   = 1'b1;
          end
          PH_SP_RISE: begin
            phase_d = PH_IDLE;
            scl_d   = 1'b1;
            sda_d   = 1'b1;
            done    = 1'b1;
          end
          PH_AK_HI: begin
            phase_d = PH_AK_LO;
            scl_d   = 1'b0;
          end
          PH_AK_LO: begin
            phase_d = PH_IDLE;
            scl_d   = 1'b0;
            done    = 1'b1;
          end
          PH_WR_SET: begin
            phase_d = PH_WR_HIGH;
            scl_d   = 1'b1;
          end
          PH_WR_HIGH: begin
            if (bit_q < BITS_PER_BYTE) begin
              bit_d   = bit_inc;
              phase_d = PH_WR_SET;
              scl_d   = 1'b0;
              sda_d   = (bit_inc < BITS_PER_BYTE) ? held_q[~bit_inc[2:0]] : 1'b1;
            end else if (!q_word_i.sda_in) begin
              phase_d = PH_IDLE;
              scl_d   = 1'b0;
              sda_d   = 1'b1;
              done    = 1'b1;
            end else begin
              if (max_retry_q != '0 && retries_q >= max_retry_q) begin
                gave_d = 1'b1;
              end else if (retries_q != RETRY_SAT) begin
                retries_d = retries_q + BYTE_W'(1);
              end
              phase_d = PH_NK_LO;
              scl_d   = 1'b0;
              sda_d   = 1'b0;
            end
          end
          PH_NK_LO: begin
            phase_d = gave_q ? PH_SP_LO : PH_RS_SP_LO;
            scl_d   = 1'b1;
            sda_d   = 1'b0;
          end
          PH_RS_SP_LO: begin
            phase_d = PH_RS_SP_RISE;
            scl_d   = 1'b1;
            sda_d   = 1'b1;
          end
          PH_RS_SP_RISE: begin
            phase_d = PH_RS_ST_HI;
            scl_d   = 1'b1;
            sda_d   = 1'b1;
          end
          PH_RS_ST_HI: begin
            phase_d = PH_RS_ST_FALL;
            scl_d   = 1'b1;
            sda_d   = 1'b0;
          end
          PH_RS_ST_FALL: begin
            bit_d   = '0;
            phase_d = PH_WR_SET;
            scl_d   = 1'b0;
            sda_d   = held_q[BYTE_W-1];
          end
          PH_RD_HIGH: begin
            shift_d = {shift_q[BYTE_W-2:0], q_word_i.sda_in};
            phase_d = PH_RD_LOW;
            scl_d   = 1'b0;
            sda_d   = 1'b1;
          end
          PH_RD_LOW: begin
            bit_d = bit_inc;
            if (bit_inc >= BITS_PER_BYTE) begin
              phase_d = PH_IDLE;
              scl_d   = 1'b0;
              sda_d   = 1'b1;
              done    = 1'b1;
            end else begin
              phase_d = PH_RD_HIGH;
              scl_d   = 1'b1;
              sda_d   = 1'b1;
            end
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_comb begin
    out_word_d.scl_level   = scl_d;
    out_word_d.sda_level   = sda_d;
    out_word_d.busy_res    = phase_d != PH_IDLE;
    out_word_d.done_res    = done;
    out_word_d.read_data   = shift_d;
    out_word_d.gave_up     = gave_d;
    out_word_d.retry_count = retries_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q      <= DIV_WIDTH'(5);
      max_retry_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_HALF_PERIOD) begin
        half_q <= DIV_WIDTH'(cfg_wdata_i);
      end else if (cfg_idx_i == REG_MAX_RETRIES) begin
        max_retry_q <= cfg_wdata_i[BYTE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      bit_q     <= '0;
      shift_q   <= '0;
      held_q    <= '0;
      tick_q    <= '0;
      retries_q <= '0;
      scl_q     <= 1'b1;
      sda_q     <= 1'b1;
      gave_q    <= 1'b0;
    end else if (step) begin
      phase_q   <= phase_d;
      bit_q     <= bit_d;
      shift_q   <= shift_d;
      held_q    <= held_d;
      tick_q    <= tick_d;
      retries_q <= retries_d;
      scl_q     <= scl_d;
      sda_q     <= sda_d;
      gave_q    <= gave_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_word_q <= out_word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  a_phase_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(phase_q))
    else $error("phase register not one-hot");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_word_q.done_res |-> !out_word_q.busy_res)
    else $error("done word shows busy");

  a_bit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_q <= BITS_PER_BYTE)
    else $error("bit index out of range");

  a_step_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_q)
    else $error("stepped word not presented");

endmodule

// ===== rtl/core/i2c_master_byte_engine.sv =====
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// I2C master that drives SCL and SDA one tick per input word.
//
// Input channel (in_valid_i / in_stall_o / in_word_i): one word per bus tick,
// carrying a command, the byte to write, the ack level to send and the
// sampled SDA level. Commands that arrive while a command is in progress
// are ignored; the word still counts as one tick.
// Output channel (out_valid_o / out_stall_i / out_word_o): exactly one result
// word per input word, in order, showing the SCL/SDA levels after that tick
// plus busy, done, read byte, give-up flag and retry count.
// Configuration (cfg_we_i / cfg_idx_i / cfg_wdata_i): index 0 sets the SCL
// half period in ticks, index 1 the retry cap (0 is unlimited). Write only
// while the engine is idle and drained.
// An accepted input word passes through the operation queue and then the
// output register before its result appears. Throughput: one word per
// cycle while out_stall_i is low, as the bus state machine steps once per word.
// Reset: SCL and SDA released, engine idle, half period 5, retry cap 0.
// A stalled receiver holds the output word; the two-entry queue then fills
// and in_stall_o rises.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine #(
  parameter int unsigned DIV_WIDTH = 10
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [i2cme_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [i2cme_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  i2cme_pkg::in_word_t              in_word_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output i2cme_pkg::out_word_t             out_word_o
);
  import i2cme_pkg::*;

  q_ctrl_t  q_ctrl;
  op_word_t q_wr_word;
  op_word_t q_rd_word;
  logic     q_full;
  logic     q_valid;
  logic     q_pop;

  i2cme_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .q_full_i   (q_full),
    .q_ctrl_o   (q_ctrl),
    .q_word_o   (q_wr_word)
  );

  i2cme_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (q_ctrl),
    .wr_word_i (q_wr_word),
    .pop_i     (q_pop),
    .full_o    (q_full),
    .valid_o   (q_valid),
    .rd_word_o (q_rd_word)
  );

  i2cme_back #(
    .DIV_WIDTH (DIV_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_valid_i   (q_valid),
    .q_word_i    (q_rd_word),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule
